// ===== src/skbaw_pkg.sv =====
package skbaw_pkg;

   localparam int NUM_DIGITS = 8;
   localparam int BLOCK_BITS = 18;

   typedef logic [2:0]            digit_type;
   typedef logic [2:0]            level_type;
   typedef logic [6:0]            pct_type;
   typedef logic [BLOCK_BITS-1:0] block_type;

   // Digits are held unbiased (raw = signed value - minimum).
   localparam logic [4:0] DIG_OFS  [NUM_DIGITS] = '{5'd0, 5'd2, 5'd5, 5'd7,
                                                    5'd10, 5'd12, 5'd14, 5'd16};
   localparam digit_type  DIG_TOP  [NUM_DIGITS] = '{3'd3, 3'd7, 3'd3, 3'd7,
                                                    3'd3, 3'd3, 3'd3, 3'd3};
   localparam digit_type  DIG_ZERO [NUM_DIGITS] = '{3'd2, 3'd4, 3'd2, 3'd4,
                                                    3'd2, 3'd2, 3'd2, 3'd2};

   localparam pct_type PCT_FULL = 7'd100;

   // floor(x/5) = (x*205) >> 10 for x <= 300
   localparam logic [15:0] DIV5_MUL   = 16'd205;
   localparam int          DIV5_SHIFT = 10;
   // floor(x/100) = (x*1311) >> 17 for x <= 4000
   localparam logic [22:0] DIV100_MUL   = 23'd1311;
   localparam int          DIV100_SHIFT = 17;

   localparam logic OP_SEED = 1'b0;
   localparam logic OP_STEP = 1'b1;

   localparam logic REG_RAND_JUMP   = 1'b0;
   localparam logic REG_INWARD_SKEW = 1'b1;

   localparam logic [1:0] CFG_SETTLE = 2'd3;

endpackage

// ===== src/skewed_block_address_walker.sv =====
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | req_opcode, req_roll, req_fresh_word
// rsp     | out       | rsp_valid/rsp_stall | rsp_block_number, rsp_level
// csr     | in        | psel/penable/pready | paddr, pwrite, pwdata, prdata
//
// One word per cycle when not stalled; input register, then result register.
// The digit update and pack sit between the input register and the result register.
// After reset and after any register write, req_stall is held high while
// the four-stage threshold pipeline settles from the new register values.
// rsp_stall holds the result register; the input register keeps accepting while it is
// empty or the result register is free or is being drained in the same cycle.
module skewed_block_address_walker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  skbaw_pkg::pct_type    req_roll,
   input  logic [17:0]           req_fresh_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output skbaw_pkg::block_type  rsp_block_number,
   output skbaw_pkg::level_type  rsp_level,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import skbaw_pkg::*;

   // ---------------------------------------------------------------- registers
   pct_type    rand_ff, rand_in;
   pct_type    skew_ff, skew_in;
   logic [1:0] busy_ff, busy_in;
   logic       cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      rand_in = rand_ff;
      skew_in = skew_ff;
      busy_in = (busy_ff != 2'd0) ? busy_ff - 2'd1 : busy_ff;
      if (cfg_write) begin
         busy_in = CFG_SETTLE;
         case (paddr[2])
            REG_RAND_JUMP:   rand_in = pwdata[6:0];
            REG_INWARD_SKEW: skew_in = pwdata[6:0];
            default:         rand_in = rand_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_RAND_JUMP:   prdata = {25'd0, rand_ff};
         REG_INWARD_SKEW: prdata = {25'd0, skew_ff};
         default:         prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rand_ff <= 7'd0;
         skew_ff <= 7'd50;
         busy_ff <= CFG_SETTLE;
      end else begin
         rand_ff <= rand_in;
         skew_ff <= skew_in;
         busy_ff <= busy_in;
      end
   end

   // ------------------------------------------------------ threshold pipeline
   // Stage A: saturate, split the remainder into 2/5 up-down and 3/5 side share.
   pct_type     rand_sat, skew_sat, rem;
   logic [15:0] jud_prod, jlr_prod;
   logic [8:0]  rem3;
   logic [5:0]  jlr;
   logic [5:0]  jud_a_ff, jud_a_in;
   logic [4:0]  side_a_ff, side_a_in;
   pct_type     rand_a_ff, skew_a_ff, skew_inv_a_ff;

   always_comb begin
      rand_sat  = (rand_ff > PCT_FULL) ? PCT_FULL : rand_ff;
      skew_sat  = (skew_ff > PCT_FULL) ? PCT_FULL : skew_ff;
      rem       = PCT_FULL - rand_sat;
      rem3      = 9'(rem) * 9'd3;
      jud_prod  = 16'({rem, 1'b0}) * DIV5_MUL;
      jlr_prod  = 16'(rem3) * DIV5_MUL;
      jud_a_in  = 6'(jud_prod >> DIV5_SHIFT);
      jlr       = 6'(jlr_prod >> DIV5_SHIFT);
      side_a_in = jlr[5:1];
   end

   // Stage B: scale the up-down share by the skew and its complement.
   logic [11:0] prod_in_b_ff, prod_out_b_ff;
   pct_type     rand_b_ff;
   logic [4:0]  side_b_ff;

   // Stage C: divide both products by 100.
   logic [22:0] quo_in_prod, quo_out_prod;
   logic [5:0]  in_c_ff, out_c_ff;
   pct_type     rand_c_ff;
   logic [4:0]  side_c_ff;

   assign quo_in_prod  = 23'(prod_in_b_ff) * DIV100_MUL;
   assign quo_out_prod = 23'(prod_out_b_ff) * DIV100_MUL;

   // Stage D: cumulative bounds.
   pct_type t0_ff, t1_ff, t2_ff, t3_ff, t4_ff;
   pct_type t1_in, t2_in, t3_in, t4_in;

   always_comb begin
      t1_in = rand_c_ff + 7'(in_c_ff);
      t2_in = t1_in + 7'(out_c_ff);
      t3_in = t2_in + 7'(side_c_ff);
      t4_in = t3_in + 7'(side_c_ff);
   end

   always_ff @(posedge clock) begin
      jud_a_ff      <= jud_a_in;
      side_a_ff     <= side_a_in;
      rand_a_ff     <= rand_sat;
      skew_a_ff     <= skew_sat;
      skew_inv_a_ff <= PCT_FULL - skew_sat;

      prod_in_b_ff  <= 12'(jud_a_ff) * 12'(skew_a_ff);
      prod_out_b_ff <= 12'(jud_a_ff) * 12'(skew_inv_a_ff);
      rand_b_ff     <= rand_a_ff;
      side_b_ff     <= side_a_ff;

      in_c_ff   <= 6'(quo_in_prod >> DIV100_SHIFT);
      out_c_ff  <= 6'(quo_out_prod >> DIV100_SHIFT);
      rand_c_ff <= rand_b_ff;
      side_c_ff <= side_b_ff;

      t0_ff <= rand_c_ff;
      t1_ff <= t1_in;
      t2_ff <= t2_in;
      t3_ff <= t3_in;
      t4_ff <= t4_in;
   end

   // ------------------------------------------------------------ handshake
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_opcode_ff;
   pct_type     s1_roll_ff;
   logic [17:0] s1_word_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        out_load, req_take;

   // Advance the input word when the result register is empty or drains now.
   assign out_load  = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (busy_ff != 2'd0) || (s1_valid_ff && !out_load);
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_load);
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   // ------------------------------------------------------------- walk step
   digit_type digits_ff [NUM_DIGITS];
   digit_type digits_in [NUM_DIGITS];
   digit_type seed_digits [NUM_DIGITS];
   level_type cursor_ff, cursor_in;
   digit_type cur_digit;
   block_type block_in;
   block_type rsp_block_ff;
   level_type rsp_level_ff;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         seed_digits[i] = 3'(s1_word_ff >> DIG_OFS[i]) & DIG_TOP[i];
      end
      digits_in = digits_ff;
      cursor_in = cursor_ff;
      cur_digit = digits_ff[cursor_ff];
      if (s1_opcode_ff == OP_SEED) begin
         digits_in = seed_digits;
         cursor_in = 3'd0;
      end else if (s1_roll_ff < t0_ff) begin
         // reseed, cursor stays
         digits_in = seed_digits;
      end else if (s1_roll_ff < t1_ff) begin
         // move in: drop the digit we leave
         if (cursor_ff != 3'd0) begin
            digits_in[cursor_ff] = DIG_ZERO[cursor_ff];
            cursor_in            = cursor_ff - 3'd1;
         end
      end else if (s1_roll_ff < t2_ff) begin
         // move out: clear the digit we enter
         if (cursor_ff != 3'd7) begin
            cursor_in                    = cursor_ff + 3'd1;
            digits_in[cursor_ff + 3'd1]  = DIG_ZERO[cursor_ff + 3'd1];
         end
      end else if (s1_roll_ff < t3_ff) begin
         if (cur_digit != 3'd0) begin
            digits_in[cursor_ff] = cur_digit - 3'd1;
         end
      end else if (s1_roll_ff < t4_ff) begin
         if (cur_digit != DIG_TOP[cursor_ff]) begin
            digits_in[cursor_ff] = cur_digit + 3'd1;
         end
      end
      block_in = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         block_in = block_in | (BLOCK_BITS'(digits_in[i]) << DIG_OFS[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cursor_ff    <= 3'd0;
         digits_ff    <= DIG_ZERO;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (out_load) begin
            cursor_ff <= cursor_in;
            digits_ff <= digits_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_opcode_ff <= req_opcode;
         s1_roll_ff   <= req_roll;
         s1_word_ff   <= req_fresh_word;
      end
      if (out_load) begin
         rsp_block_ff <= block_in;
         rsp_level_ff <= cursor_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_block_number = rsp_block_ff;
   assign rsp_level        = rsp_level_ff;

`ifndef NO_ASSERTIONS
   a_settle_stall : assert property (@(posedge clock) disable iff (reset)
      busy_ff != 2'd0 |-> req_stall)
      else $error("word accepted while thresholds settle");

   a_seed_clears : assert property (@(posedge clock) disable iff (reset)
      out_load && s1_opcode_ff == OP_SEED |=> cursor_ff == 3'd0)
      else $error("seed left cursor nonzero");

   a_step_move : assert property (@(posedge clock) disable iff (reset)
      out_load && s1_opcode_ff == OP_STEP |=>
         (cursor_ff == $past(cursor_ff) || cursor_ff == $past(cursor_ff) + 3'd1 ||
          cursor_ff == $past(cursor_ff) - 3'd1))
      else $error("cursor moved more than one level");

   a_level_tracks : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_level_ff == cursor_ff)
      else $error("result level differs from cursor");
`endif

endmodule
